>>> hdl/mcq_pkg.sv
// ---------------------------------------------------------------------------
// mcq_pkg
// Shared constants and types for the Morton code quantizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mcq_pkg;

    localparam int AXIS_BITS = 10;
    localparam int COORD_W   = 32;
    localparam int MORTON_W  = 30;
    localparam int DIV_W     = COORD_W + AXIS_BITS;
    localparam int Q_W       = AXIS_BITS + 1;
    localparam int N_CELLS   = AXIS_BITS + 1;
    localparam int CODE_W    = 3 * AXIS_BITS;
    localparam int WIDE_W    = (CODE_W > MORTON_W) ? CODE_W : MORTON_W;
    localparam int N_AXES    = 3;
    localparam int ADDR_W    = 5;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_EXT_X = 3'd3;
    localparam logic [2:0] REG_EXT_Y = 3'd4;
    localparam logic [2:0] REG_EXT_Z = 3'd5;

    typedef struct packed {
        logic             zero;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dv;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        logic                   valid;
        t_lane [N_AXES-1:0]     lane;
    } t_word;

endpackage

`default_nettype wire

>>> hdl/mcq_cell.sv
// ---------------------------------------------------------------------------
// mcq_cell
// One restoring division step for all three axes, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module mcq_cell import mcq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_word i_word,
    output t_word      o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        logic bit_q;
        n_word = i_word;
        for (int a = 0; a < N_AXES; a++) begin
            bit_q = (i_word.lane[a].rem >= i_word.lane[a].dv);
            n_word.lane[a].rem = bit_q ? (i_word.lane[a].rem - i_word.lane[a].dv)
                                       : i_word.lane[a].rem;
            n_word.lane[a].dv  = i_word.lane[a].dv >> 1;
            n_word.lane[a].q   = {i_word.lane[a].q[Q_W-2:0], bit_q};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.lane <= n_word.lane;
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> hdl/morton_code_3d_quantizer.sv
// ---------------------------------------------------------------------------
// morton_code_3d_quantizer
// Quantizes a Q16.16 point into a box and interleaves a 30-bit Morton code.
// ---------------------------------------------------------------------------
// An accepted point's result strobes on o_done after passing the front stage,
// AXIS_BITS+1 division cells and the output register.
// Throughput: one point per cycle; busy stays low, the cell chain sets the depth.
// Reset: synchronous, clears valid bits and box registers to zero.
// The receiver cannot stall; every result is shown for one cycle.
`default_nettype none

module morton_code_3d_quantizer import mcq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [COORD_W-1:0]  i_point_x,
    input  wire logic [COORD_W-1:0]  i_point_y,
    input  wire logic [COORD_W-1:0]  i_point_z,
    output logic                     o_done,
    output logic [MORTON_W-1:0]      o_morton_code,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int LAT = AXIS_BITS + 3;

    logic [COORD_W-1:0] r_min [N_AXES];
    logic [COORD_W-1:0] r_ext [N_AXES];
    logic [COORD_W-1:0] w_pt  [N_AXES];

    t_word r_front;
    t_word n_front;
    t_word w_chain [N_CELLS+1];

    logic                r_done;
    logic [MORTON_W-1:0] r_code;
    logic [WIDE_W-1:0]   n_code;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_min[a] <= '0;
                r_ext[a] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_MIN_X: r_min[0] <= pwdata;
                REG_MIN_Y: r_min[1] <= pwdata;
                REG_MIN_Z: r_min[2] <= pwdata;
                REG_EXT_X: r_ext[0] <= pwdata;
                REG_EXT_Y: r_ext[1] <= pwdata;
                REG_EXT_Z: r_ext[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MIN_X: prdata = r_min[0];
            REG_MIN_Y: prdata = r_min[1];
            REG_MIN_Z: prdata = r_min[2];
            REG_EXT_X: prdata = r_ext[0];
            REG_EXT_Y: prdata = r_ext[1];
            REG_EXT_Z: prdata = r_ext[2];
            default:   prdata = '0;
        endcase
    end

    // front: difference, zero flag, scale by 2^AXIS_BITS-1, shifted divisor
    always_comb begin
        logic [COORD_W:0] diff;
        logic [DIV_W-1:0] dext;
        n_front.valid = start;
        for (int a = 0; a < N_AXES; a++) begin
            diff = {w_pt[a][COORD_W-1], w_pt[a]} - {r_min[a][COORD_W-1], r_min[a]};
            dext = {{AXIS_BITS{1'b0}}, diff[COORD_W-1:0]};
            n_front.lane[a].zero = (r_ext[a] == '0) || diff[COORD_W] || (diff == '0);
            n_front.lane[a].rem  = (dext << AXIS_BITS) - dext;
            n_front.lane[a].dv   = {r_ext[a], {AXIS_BITS{1'b0}}};
            n_front.lane[a].q    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front.lane <= n_front.lane;
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front.valid <= n_front.valid;
        end
    end

    assign w_chain[0] = r_front;

    for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
        mcq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[c]),
            .o_word  (w_chain[c+1])
        );
    end

    // saturate, force zero, interleave
    always_comb begin
        logic [AXIS_BITS-1:0] qv [N_AXES];
        for (int a = 0; a < N_AXES; a++) begin
            if (w_chain[N_CELLS].lane[a].zero) begin
                qv[a] = '0;
            end else if (w_chain[N_CELLS].lane[a].q[AXIS_BITS]) begin
                qv[a] = '1;
            end else begin
                qv[a] = w_chain[N_CELLS].lane[a].q[AXIS_BITS-1:0];
            end
        end
        n_code = '0;
        for (int b = 0; b < AXIS_BITS; b++) begin
            n_code[3*b]   = qv[0][b];
            n_code[3*b+1] = qv[1][b];
            n_code[3*b+2] = qv[2][b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code[MORTON_W-1:0];
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_chain[N_CELLS].valid;
        end
    end

    assign o_done        = r_done;
    assign o_morton_code = r_code;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without accepted point");
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_done)
        else $error("result strobe after reset");

endmodule

`default_nettype wire

>>> tb/sv/mcq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcq_checker
// Watches the point and code channels of the Morton quantizer, predicts each
// code from a private copy of the box registers and compares in order.
// ---------------------------------------------------------------------------
`default_nettype none

module mcq_checker import mcq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [COORD_W-1:0]  i_point_x,
    input  wire logic [COORD_W-1:0]  i_point_y,
    input  wire logic [COORD_W-1:0]  i_point_z,
    input  wire logic                o_done,
    input  wire logic [MORTON_W-1:0] o_morton_code,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                pready,
    output int                       o_errors,
    output int                       o_pending
);

    logic [31:0] box_min [N_AXES];
    logic [31:0] box_ext [N_AXES];
    logic [MORTON_W-1:0] code_q [$];

    function automatic logic [AXIS_BITS-1:0] quantize(logic [31:0] pt, logic [31:0] mn,
                                                       logic [31:0] ext);
        logic signed [32:0] diff;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] top;
        top = (64'd1 << AXIS_BITS) - 1;
        if (ext == 0) return '0;
        diff = $signed({pt[31], pt}) - $signed({mn[31], mn});
        if (diff <= 0) return '0;
        prod = {31'd0, diff} * top;
        q = prod / {32'd0, ext};
        return (q > top) ? top[AXIS_BITS-1:0] : q[AXIS_BITS-1:0];
    endfunction

    function automatic logic [MORTON_W-1:0] morton_of(logic [31:0] px, logic [31:0] py,
                                                      logic [31:0] pz);
        logic [AXIS_BITS-1:0] qx, qy, qz;
        logic [CODE_W-1:0] code;
        qx = quantize(px, box_min[0], box_ext[0]);
        qy = quantize(py, box_min[1], box_ext[1]);
        qz = quantize(pz, box_min[2], box_ext[2]);
        code = '0;
        for (int b = 0; b < AXIS_BITS; b++) begin
            code[3*b]   = qx[b];
            code[3*b+1] = qy[b];
            code[3*b+2] = qz[b];
        end
        return code[MORTON_W-1:0];
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    assign o_pending = code_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        logic [MORTON_W-1:0] want;
        if (!i_rst_n) begin
            for (int a = 0; a < N_AXES; a++) begin
                box_min[a] = '0;
                box_ext[a] = '0;
            end
        end else begin
            if (o_done) begin
                if (code_q.size() == 0) begin
                    report($sformatf("unexpected code %h", o_morton_code));
                end else begin
                    want = code_q.pop_front();
                    if (o_morton_code !== want)
                        report($sformatf("morton_code got %h want %h", o_morton_code, want));
                end
            end
            if (start && !busy)
                code_q.push_back(morton_of(i_point_x, i_point_y, i_point_z));
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_MIN_X: box_min[0] = pwdata;
                    REG_MIN_Y: box_min[1] = pwdata;
                    REG_MIN_Z: box_min[2] = pwdata;
                    REG_EXT_X: box_ext[0] = pwdata;
                    REG_EXT_Y: box_ext[1] = pwdata;
                    REG_EXT_Z: box_ext[2] = pwdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives points and box settings into the Morton quantizer with random gaps;
// the checker predicts and compares every code word.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import mcq_pkg::*;

    logic i_clk, i_rst_n;
    logic start, busy;
    logic [COORD_W-1:0] i_point_x, i_point_y, i_point_z;
    logic o_done;
    logic [MORTON_W-1:0] o_morton_code;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    int errors, pending, cycles, sent;

    morton_code_3d_quantizer u_dut (.*);

    mcq_checker u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_point_x, .i_point_y, .i_point_z,
        .o_done, .o_morton_code, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .o_errors(errors), .o_pending(pending)
    );

    localparam int LIMIT = 200000;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        do @(negedge i_clk); while (!pready);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic set_box(logic [31:0] mx, my, mz, ex, ey, ez);
        write_reg(REG_MIN_X, mx); write_reg(REG_MIN_Y, my); write_reg(REG_MIN_Z, mz);
        write_reg(REG_EXT_X, ex); write_reg(REG_EXT_Y, ey); write_reg(REG_EXT_Z, ez);
    endtask

    task automatic send_point(logic [31:0] px, py, pz, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start = 0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        start = 1; i_point_x = px; i_point_y = py; i_point_z = pz;
        do @(negedge i_clk); while (busy);
        sent++;
    endtask

    function automatic logic [31:0] rnd_coord(logic [31:0] mn, logic [31:0] ex);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return mn - $urandom_range(0, 3);
            2: return mn + ex + $urandom_range(0, 3);
            default: return mn + ($urandom() % (ex == 0 ? 32'd1 : ex));
        endcase
    endfunction

    initial begin
        logic [31:0] mn [3];
        logic [31:0] ex [3];
        cycles = 0; sent = 0;
        i_rst_n = 0; start = 0; psel = 0; penable = 0; pwrite = 0;
        paddr = '0; pwdata = '0; i_point_x = '0; i_point_y = '0; i_point_z = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        // reset box: all extents zero
        send_point(32'h7fffffff, 32'h80000000, 32'h12345678, 0);
        start = 0;
        drain();

        set_box(32'h0, 32'hffff0000, 32'h80000000, 32'h00010000, 32'h00100000, 32'hffffffff);
        send_point(32'h0, 32'hffff0000, 32'h80000000, 0);
        send_point(32'h0000ffff, 32'h000effff, 32'h7ffffffe, 0);
        send_point(32'h00010000, 32'h000f0000, 32'h7fffffff, 0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_point(32'hffffffff, 32'h00000000, 32'h00000000, 0);
        send_point(32'h00008000, 32'h00070000, 32'h00000001, 0);
        start = 0;
        drain();

        set_box(32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'h0, 32'h1);
        send_point(32'h80000000, 32'h7fffffff, 32'h1, 0);
        send_point(32'h7fffffff, 32'h80000001, 32'h0, 0);
        send_point(32'h55555555, 32'haaaaaaaa, 32'hffffffff, 0);
        start = 0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            for (int a = 0; a < 3; a++) begin
                mn[a] = $urandom();
                case ($urandom_range(0, 4))
                    0: ex[a] = 0;
                    1: ex[a] = $urandom_range(1, 2000);
                    2: ex[a] = 32'hffffffff;
                    default: ex[a] = $urandom();
                endcase
            end
            set_box(mn[0], mn[1], mn[2], ex[0], ex[1], ex[2]);
            for (int k = 0; k < 75; k++)
                send_point(rnd_coord(mn[0], ex[0]), rnd_coord(mn[1], ex[1]),
                           rnd_coord(mn[2], ex[2]), phase < 5);
            start = 0;
            drain();
        end
        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/mcq_pkg.sv
hdl/mcq_cell.sv
hdl/morton_code_3d_quantizer.sv
tb/sv/mcq_checker.sv
tb/sv/testbench.sv
